// File: rtl/core/wam_pkg.sv
// ---------------------------------------------------------------------------
// wam_pkg: shared definitions for the window anagram matcher
// Default sizes and the packed widths of the stream words.
// ---------------------------------------------------------------------------
package wam_pkg;

  localparam int MAX_PATTERN_DEF = 256;
  localparam int ALPHABET_DEF    = 26;

  // Letter index width on the input word.
  localparam int CH_W = 5;

  // Stream word widths (fields packed from bit 0, padded to whole bytes).
  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 8;

  // Item kinds carried in the lowest tuser bit of the input word.
  localparam logic FUNC_PATTERN = 1'b0;
  localparam logic FUNC_TEXT    = 1'b1;

endpackage : wam_pkg

// File: rtl/core/window_anagram_matcher.sv
// ---------------------------------------------------------------------------
// window_anagram_matcher: sliding-window anagram search over a letter stream
// A result word appears in the cycle after its input word is taken.
// Throughput: one word per cycle while out_tready is high; the output register
// frees itself in the same cycle as it is drained, so in_tready stays high under full flow.
// Reset: synchronous, active low; histograms, lengths, pointers, the found
// flag and the output valid are cleared. The history ring is not cleared.
// ---------------------------------------------------------------------------
module window_anagram_matcher
  import wam_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int ALPHABET    = ALPHABET_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [4:0] ch, [7:5] zero
  input  logic [IN_USER_W-1:0]  in_tuser,   // [0] func, [1] first
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [0] match, [1] found,
                                            // [2] pattern_full, [7:3] zero
);

  // Length counters must hold MAX_PATTERN itself; ring pointers index it.
  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int SW = LW + 1;

  // Stream handshake and field unpacking.
  logic            in_acc;
  logic            in_func;
  logic            in_first;
  logic [CH_W-1:0] in_ch;
  logic            ch_ok;

  assign in_acc   = in_tvalid & in_tready;
  assign in_func  = in_tuser[0];
  assign in_first = in_tuser[1];
  assign in_ch    = in_tdata[CH_W-1:0];
  // A letter beyond the alphabet is ignored, though clearing still happens.
  assign ch_ok    = (7'(in_ch) < 7'(ALPHABET));

  // Block state.
  logic [LW-1:0] pat_r   [ALPHABET];
  logic [LW-1:0] pat_nxt [ALPHABET];
  logic [LW-1:0] win_r   [ALPHABET];
  logic [LW-1:0] win_nxt [ALPHABET];
  logic [LW-1:0] plen_r, plen_nxt;
  logic [LW-1:0] tpos_r, tpos_nxt;
  logic [AW-1:0] wr_r, wr_nxt;
  logic          found_r, found_nxt;

  // Output register.
  logic out_valid_r, out_valid_nxt;
  logic match_r, match_nxt;
  logic outfound_r;
  logic full_r, full_nxt;

  // History ring: one write and one registered read per cycle. The read
  // port always prefetches the letter that leaves the window on the next
  // text word, so the eviction needs no extra cycle. When that letter is
  // the one being written in the same cycle it is bypassed around the
  // memory.
  logic [CH_W-1:0] ring [MAX_PATTERN];
  logic            ring_we;
  logic [AW-1:0]   ring_wa;
  logic [AW-1:0]   rd_addr;
  logic [SW-1:0]   rd_sum;
  logic [CH_W-1:0] rd_ch_r;
  logic            byp_r;
  logic [CH_W-1:0] byp_ch_r;
  logic [CH_W-1:0] old_ch;
  logic            drop_old;

  assign old_ch = byp_r ? byp_ch_r : rd_ch_r;

  // The input side waits only while a finished word is still unclaimed.
  assign in_tready = ~out_valid_r | out_tready;

  always_comb begin
    logic inc;
    logic dec;
    logic eq;
    pat_nxt   = pat_r;
    win_nxt   = win_r;
    plen_nxt  = plen_r;
    tpos_nxt  = tpos_r;
    wr_nxt    = wr_r;
    found_nxt = found_r;
    ring_we   = 1'b0;
    ring_wa   = wr_r;
    match_nxt = 1'b0;
    full_nxt  = 1'b0;
    drop_old  = 1'b0;
    eq        = 1'b1;
    inc       = 1'b0;
    dec       = 1'b0;

    if (in_acc) begin
      if (in_func == FUNC_PATTERN) begin
        if (in_first) begin
          for (int k = 0; k < ALPHABET; k++) pat_nxt[k] = '0;
          plen_nxt = '0;
        end
        // Any change of pattern restarts the text.
        for (int k = 0; k < ALPHABET; k++) win_nxt[k] = '0;
        tpos_nxt  = '0;
        wr_nxt    = '0;
        found_nxt = 1'b0;
        if (ch_ok) begin
          if (plen_nxt == LW'(MAX_PATTERN)) begin
            full_nxt = 1'b1;
          end else begin
            for (int k = 0; k < ALPHABET; k++) begin
              if (7'(in_ch) == 7'(k)) pat_nxt[k] = pat_nxt[k] + LW'(1);
            end
            plen_nxt = plen_nxt + LW'(1);
          end
        end
      end else begin
        if (in_first) begin
          for (int k = 0; k < ALPHABET; k++) win_nxt[k] = '0;
          tpos_nxt  = '0;
          wr_nxt    = '0;
          found_nxt = 1'b0;
        end
        if (ch_ok && (plen_r != '0)) begin
          // Once the window is full the oldest letter leaves it.
          drop_old = (tpos_nxt >= plen_r);
          for (int k = 0; k < ALPHABET; k++) begin
            inc = (7'(in_ch) == 7'(k));
            dec = drop_old && (7'(old_ch) == 7'(k)) && ((win_nxt[k] != '0) || inc);
            win_nxt[k] = win_nxt[k] + LW'(inc) - LW'(dec);
          end
          ring_we = 1'b1;
          ring_wa = wr_nxt;
          wr_nxt  = (wr_nxt == AW'(MAX_PATTERN - 1)) ? '0 : wr_nxt + AW'(1);
          if (tpos_nxt != LW'(MAX_PATTERN)) tpos_nxt = tpos_nxt + LW'(1);
        end
        for (int k = 0; k < ALPHABET; k++) begin
          if (pat_r[k] != win_nxt[k]) eq = 1'b0;
        end
        match_nxt = eq;
        if (eq) found_nxt = 1'b1;
      end
    end

    // Address of the letter that leaves the window next, modulo the ring.
    rd_sum = SW'(wr_nxt) + SW'(MAX_PATTERN) - SW'(plen_nxt);
    if (rd_sum >= SW'(MAX_PATTERN)) rd_sum = rd_sum - SW'(MAX_PATTERN);
    rd_addr = AW'(rd_sum);

    out_valid_nxt = in_acc | (out_valid_r & ~out_tready);
  end

  // Ring memory with registered read and write bypass.
  always_ff @(posedge clk) begin
    if (ring_we) ring[ring_wa] <= in_ch;
    rd_ch_r  <= ring[rd_addr];
    byp_r    <= ring_we && (ring_wa == rd_addr);
    byp_ch_r <= in_ch;
  end

  // Control state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ALPHABET; k++) begin
        pat_r[k] <= '0;
        win_r[k] <= '0;
      end
      plen_r      <= '0;
      tpos_r      <= '0;
      wr_r        <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pat_r       <= pat_nxt;
      win_r       <= win_nxt;
      plen_r      <= plen_nxt;
      tpos_r      <= tpos_nxt;
      wr_r        <= wr_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload is loaded with each accepted word and needs no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      match_r    <= match_nxt;
      outfound_r <= found_nxt;
      full_r     <= full_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, full_r, outfound_r, match_r};

endmodule : window_anagram_matcher

// File: rtl/core/wam_checker.sv
// ---------------------------------------------------------------------------
// wam_checker: port-level checks for the window anagram matcher
// Watches the stream ports and is bound to the top level below.
// ---------------------------------------------------------------------------
module wam_checker
  import wam_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_USER_W-1:0]  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // A result word is held until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed or dropped while stalled");

  // An empty output register never blocks the input side.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output register");

  // A pattern word yields no match and clears the found flag.
  a_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == FUNC_PATTERN)
      |=> out_tvalid && !out_tdata[0] && !out_tdata[1])
    else $error("pattern word reported a match or found");

  // A match always sets found and never comes with a full store.
  a_match_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[1] && !out_tdata[2])
    else $error("match without found, or with pattern_full");

endmodule : wam_checker

bind window_anagram_matcher wam_checker u_wam_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the window anagram matcher
// Streams pattern and text words into the block. A predictor keeps its own
// pattern and window histograms and its own history ring. Each accepted word
// yields one expected verdict, and every result word is checked against the
// oldest verdict still waiting. Both stream sides idle in several phases.
// ---------------------------------------------------------------------------
module tb;
  import wam_pkg::*;

  // Flow control applied while a word is offered or drained.
  typedef enum logic [1:0] {
    PACE_FREE,        // no idling on either side
    PACE_SEND_IDLE,   // sender idle at random, about two times in three
    PACE_RECV_STALL,  // receiver stalls at random, about two times in three
    PACE_BOTH         // both sides idle now and then
  } pace_t;

  // One input word as the bench sees it, with the pace it is sent at.
  typedef struct packed {
    pace_t           pace;
    logic            func;
    logic [CH_W-1:0] ch;
    logic            first;
  } letter_word_t;

  // One result word as the predictor expects it.
  typedef struct packed {
    logic match;
    logic found;
    logic full;
  } verdict_t;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // [4:0] ch, [7:5] zero
  logic [IN_USER_W-1:0]  in_tuser   = '0;   // [0] func, [1] first
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [0] match, [1] found,
                                            // [2] pattern_full, [7:3] zero

  letter_word_t letter_q[$];    // words still to be offered
  verdict_t     verdict_q[$];   // verdicts still to arrive
  pace_t        pace_now = PACE_FREE;
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;

  // Predictor state: histograms, lengths, ring and the sticky flag.
  logic [8:0]      pat_count [ALPHABET_DEF];
  logic [8:0]      win_count [ALPHABET_DEF];
  logic [CH_W-1:0] text_ring [MAX_PATTERN_DEF];
  int unsigned     pat_len;
  int unsigned     text_len;
  int unsigned     ring_ptr;
  bit              found_seen;

  window_anagram_matcher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Starting a text empties the window and forgets any earlier match.
  function automatic void restart_text();
    int k;
    for (k = 0; k < ALPHABET_DEF; k++) win_count[k] = '0;
    text_len   = 0;
    ring_ptr   = 0;
    found_seen = 1'b0;
  endfunction

  // Advances the predictor by one accepted word and returns its verdict.
  function automatic verdict_t step_matcher(letter_word_t w);
    verdict_t    v;
    bit          known;
    bit          same;
    int unsigned rd;
    int unsigned old;
    int          k;
    v     = '0;
    known = (w.ch < ALPHABET_DEF);
    if (w.func == FUNC_PATTERN) begin
      if (w.first) begin
        for (k = 0; k < ALPHABET_DEF; k++) pat_count[k] = '0;
        pat_len = 0;
      end
      // Any pattern word drops the text in progress.
      restart_text();
      if (known) begin
        if (pat_len >= MAX_PATTERN_DEF) begin
          v.full = 1'b1;
        end else begin
          pat_count[w.ch]++;
          pat_len++;
        end
      end
    end else begin
      if (w.first) restart_text();
      if (known && pat_len > 0) begin
        win_count[w.ch]++;
        // Once the window is full the letter that falls out is removed.
        if (text_len >= pat_len) begin
          rd  = (ring_ptr + MAX_PATTERN_DEF - pat_len) % MAX_PATTERN_DEF;
          old = 32'(text_ring[rd]);
          if (old < ALPHABET_DEF && win_count[old] > 0) win_count[old]--;
        end
        text_ring[ring_ptr] = w.ch;
        ring_ptr = (ring_ptr + 1) % MAX_PATTERN_DEF;
        if (text_len < MAX_PATTERN_DEF) text_len++;
      end
      same = 1'b1;
      for (k = 0; k < ALPHABET_DEF; k++) begin
        if (pat_count[k] != win_count[k]) same = 1'b0;
      end
      if (same) begin
        v.match    = 1'b1;
        found_seen = 1'b1;
      end
    end
    v.found = found_seen;
    return v;
  endfunction

  task automatic queue_letter(logic func, int unsigned ch, logic first, pace_t pace);
    letter_word_t w;
    w.pace  = pace;
    w.func  = func;
    w.ch    = ch[CH_W-1:0];
    w.first = first;
    letter_q.push_back(w);
  endtask

  // A pattern over a few neighbouring letters, then a text over the same
  // letters. The text is partly built from shuffled copies of the pattern so
  // that matching windows turn up often. Now and then a stray letter or a
  // restart in mid-text breaks the sequence.
  task automatic queue_search(pace_t pace, int unsigned plen, int unsigned tlen,
                              bit extend);
    logic [CH_W-1:0] pat[$];
    logic [CH_W-1:0] tmp;
    int unsigned     base;
    int unsigned     span;
    int unsigned     pick;
    int unsigned     i;
    int unsigned     j;
    int unsigned     sent;
    span = $urandom_range(1, 4);
    base = $urandom_range(0, ALPHABET_DEF - span);
    if (plen == 0) begin
      // A pattern word holding no letter leaves the pattern empty.
      queue_letter(FUNC_PATTERN, $urandom_range(ALPHABET_DEF, 31), 1'b1, pace);
    end
    for (i = 0; i < plen; i++) begin
      pick = base + $urandom_range(0, span - 1);
      if (pat.size() < MAX_PATTERN_DEF) pat.push_back(pick[CH_W-1:0]);
      queue_letter(FUNC_PATTERN, pick, (i == 0) && !extend, pace);
    end
    sent = 0;
    while (sent < tlen) begin
      if ($urandom_range(0, 1) == 1 && pat.size() > 0 && pat.size() <= tlen - sent) begin
        for (j = pat.size() - 1; j > 0; j--) begin
          i      = $urandom_range(0, j);
          tmp    = pat[j];
          pat[j] = pat[i];
          pat[i] = tmp;
        end
        foreach (pat[k]) begin
          queue_letter(FUNC_TEXT, 32'(pat[k]), sent == 0, pace);
          sent++;
        end
      end else begin
        if ($urandom_range(0, 99) < 6) pick = $urandom_range(0, 31);
        else pick = base + $urandom_range(0, span - 1);
        queue_letter(FUNC_TEXT, pick, sent == 0 || $urandom_range(0, 99) < 3, pace);
        sent++;
      end
    end
  endtask

  // Stimulus: a directed opening, then four phases of random searches.
  initial begin : stimulus
    int unsigned phase;
    int unsigned goal;
    int unsigned sel;
    int unsigned n;
    int unsigned i;
    pace_t       pace;
    int          k;
    for (k = 0; k < ALPHABET_DEF; k++) pat_count[k] = '0;
    for (k = 0; k < MAX_PATTERN_DEF; k++) text_ring[k] = '0;
    pat_len = 0;
    restart_text();

    // Text straight after reset sees an empty pattern and matches at once,
    // even on a letter outside the alphabet.
    queue_letter(FUNC_TEXT, 0, 1'b1, PACE_FREE);
    queue_letter(FUNC_TEXT, 31, 1'b0, PACE_FREE);
    // Pattern "z a q" with an out-of-range letter that must be ignored.
    queue_letter(FUNC_PATTERN, 25, 1'b1, PACE_FREE);
    queue_letter(FUNC_PATTERN, 0, 1'b0, PACE_FREE);
    queue_letter(FUNC_PATTERN, 31, 1'b0, PACE_FREE);
    queue_letter(FUNC_PATTERN, 16, 1'b0, PACE_FREE);
    queue_letter(FUNC_TEXT, 16, 1'b1, PACE_FREE);
    queue_letter(FUNC_TEXT, 0, 1'b0, PACE_FREE);
    queue_letter(FUNC_TEXT, 25, 1'b0, PACE_FREE);
    queue_letter(FUNC_TEXT, 16, 1'b0, PACE_FREE);
    queue_letter(FUNC_TEXT, 29, 1'b0, PACE_FREE);
    queue_letter(FUNC_TEXT, 1, 1'b0, PACE_FREE);
    // Restarting the text clears the sticky flag.
    queue_letter(FUNC_TEXT, 0, 1'b1, PACE_FREE);
    queue_letter(FUNC_TEXT, 25, 1'b0, PACE_FREE);
    queue_letter(FUNC_TEXT, 16, 1'b0, PACE_FREE);
    // A new pattern of no letters: every text word matches.
    queue_letter(FUNC_PATTERN, 27, 1'b1, PACE_FREE);
    queue_letter(FUNC_TEXT, 3, 1'b0, PACE_FREE);
    queue_letter(FUNC_TEXT, 15, 1'b1, PACE_FREE);
    // A pattern extended without a restart, then its anagram.
    queue_letter(FUNC_PATTERN, 8, 1'b1, PACE_FREE);
    queue_letter(FUNC_PATTERN, 7, 1'b0, PACE_FREE);
    queue_letter(FUNC_TEXT, 7, 1'b1, PACE_FREE);
    queue_letter(FUNC_TEXT, 8, 1'b0, PACE_FREE);

    for (phase = 0; phase < 4; phase++) begin
      pace = pace_t'(phase);
      goal = letter_q.size() + 455;
      // A long text over a short pattern wraps the history ring; a pattern
      // longer than the store overflows it and must flag the dropped letters.
      if (phase == 0) queue_search(pace, 3, 300, 1'b0);
      if (phase == 1 || phase == 3) begin
        queue_search(pace, $urandom_range(MAX_PATTERN_DEF - 4, MAX_PATTERN_DEF + 6),
                     $urandom_range(MAX_PATTERN_DEF, MAX_PATTERN_DEF + 30), 1'b0);
      end
      while (letter_q.size() < goal) begin
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
          n = $urandom_range(1, 6);
          for (i = 0; i < n; i++) begin
            queue_letter(1'($urandom_range(0, 1)), $urandom_range(0, 31),
                         1'($urandom_range(0, 1)), pace);
          end
        end else if (sel < 12) begin
          n = $urandom_range(1, 8);
          for (i = 0; i < n; i++) begin
            queue_letter(FUNC_TEXT, $urandom_range(0, ALPHABET_DEF - 1), 1'b0, pace);
          end
        end else begin
          queue_search(pace, $urandom_range(0, 6), $urandom_range(1, 30),
                       $urandom_range(0, 9) == 0);
        end
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (letter_q.size() != 0 || in_tvalid || verdict_q.size() != 0) begin
      @(posedge clk);
    end
    // Allow a few cycles for any stray result word to show up.
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Sender: a new word is loaded once the previous one has been taken, or
  // the valid is dropped when the pace calls for idling or no word is left.
  always @(posedge clk) begin : sender
    letter_word_t w;
    bit           idle;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      idle = 1'b1;
      if (letter_q.size() != 0) begin
        case (letter_q[0].pace)
          PACE_SEND_IDLE: idle = ($urandom_range(0, 99) < 66);
          PACE_BOTH:      idle = ($urandom_range(0, 99) < 12);
          default:        idle = 1'b0;
        endcase
      end
      if (!idle) begin
        w = letter_q.pop_front();
        in_tdata  <= {{(IN_DATA_W - CH_W){1'b0}}, w.ch};
        in_tuser  <= {w.first, w.func};
        in_tvalid <= 1'b1;
        pace_now  <= w.pace;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stalls at random according to the pace of the word last sent.
  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      case (pace_now)
        PACE_RECV_STALL: out_tready <= ($urandom_range(0, 99) >= 66);
        PACE_BOTH:       out_tready <= ($urandom_range(0, 99) >= 12);
        default:         out_tready <= 1'b1;
      endcase
    end
  end

  // Scoreboard: result words are checked before the word accepted at the
  // same edge is predicted, so the oldest verdict is always the right one.
  always @(posedge clk) begin : scoreboard
    verdict_t want;
    letter_word_t w;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          $error("result word %h arrived with no verdict waiting", out_tdata);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          if (out_tdata[0] !== want.match) begin
            $error("match: expected %0b, got %0b", want.match, out_tdata[0]);
            mismatches++;
          end
          if (out_tdata[1] !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, out_tdata[1]);
            mismatches++;
          end
          if (out_tdata[2] !== want.full) begin
            $error("pattern_full: expected %0b, got %0b", want.full, out_tdata[2]);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        w.pace  = PACE_FREE;
        w.ch    = in_tdata[CH_W-1:0];
        w.func  = in_tuser[0];
        w.first = in_tuser[1];
        verdict_q.push_back(step_matcher(w));
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

endmodule
